// ----- rtl/core/hpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the hazard pointer reclaimer.
// No dependencies; hazard_pointer_reclaimer and its testbench import this package.
package hpr_pkg;

   localparam int SLOTS_PER_THREAD = 4;
   localparam int MAX_THREADS      = 8;
   localparam int RETIRE_DEPTH     = 16;

   localparam int HAZARD_SLOTS = MAX_THREADS * SLOTS_PER_THREAD;
   localparam int HAZ_AW       = (HAZARD_SLOTS > 1) ? $clog2(HAZARD_SLOTS) : 1;
   localparam int SLOT_CNT_W   = $clog2(HAZARD_SLOTS + 1);
   localparam int LST_AW       = $clog2(RETIRE_DEPTH);
   localparam int CNT_W        = $clog2(RETIRE_DEPTH + 1);

   localparam int PTR_W  = 64;
   localparam int TAG_W  = 8;
   localparam int ACT_W  = 4;
   localparam int LST_W  = PTR_W + TAG_W;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [ACT_W-1:0] ACTIVE_THREADS_RESET = ACT_W'(8);

   localparam logic CMD_SET    = 1'b0;
   localparam logic CMD_RETIRE = 1'b1;

   localparam logic STATUS_FREED    = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   localparam logic REG_ACTIVE_THREADS = 1'b0;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_LOAD   = 6'b000100,
      S_CMP    = 6'b001000,
      S_DECIDE = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

endpackage

// ----- rtl/core/hazard_pointer_reclaimer.sv -----
`timescale 1ns / 1ps
// Hazard pointer reclaimer top level; uses hpr_pkg and two hpr_ram instances.
// A set word writes one hazard slot. A retire word appends to a sixteen-entry retire
// list; the retire that fills the list starts a scan, during which no word is accepted.
// The scan checks each retired entry against the hazard slots of the active threads
// with a single 64-bit comparator fed by the hazard table's one read port, one slot
// per cycle. Freed entries come out in list order, the final one marked last; a
// retire into a list that stays full returns one rejected word. There is no clearing
// pass after reset: hazard slots carry valid bits.
module hazard_pointer_reclaimer
   import hpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [2:0]        req_thread_id,
   input  logic [1:0]        req_slot_index,
   input  logic [PTR_W-1:0]  req_pointer,
   input  logic [TAG_W-1:0]  req_callback_tag,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PTR_W-1:0]  rsp_freed_pointer,
   output logic [TAG_W-1:0]  rsp_freed_tag,
   output logic              rsp_status,
   output logic              rsp_last,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   state_type state_ff, state_in;

   logic [ACT_W-1:0]      active_ff, active_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LST_AW-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]      kept_ff, kept_in;
   logic [HAZ_AW-1:0]     slot_ff, slot_in;
   logic                  hit_ff, hit_in;
   logic [HAZARD_SLOTS-1:0] hz_valid_ff, hz_valid_in;
   logic                  hv_ff, hv_in;
   logic [PTR_W-1:0]      ent_ptr_ff, ent_ptr_in;
   logic [TAG_W-1:0]      ent_tag_ff, ent_tag_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [PTR_W-1:0]      pend_ptr_ff, pend_ptr_in;
   logic [TAG_W-1:0]      pend_tag_ff, pend_tag_in;
   logic                  out_valid_ff, out_valid_in;
   logic [PTR_W-1:0]      out_ptr_ff, out_ptr_in;
   logic [TAG_W-1:0]      out_tag_ff, out_tag_in;
   logic                  out_status_ff, out_status_in;
   logic                  out_last_ff, out_last_in;

   logic                  hz_wr_en;
   logic [HAZ_AW-1:0]     hz_wr_addr;
   logic                  hz_rd_en;
   logic [HAZ_AW-1:0]     hz_rd_addr;
   logic [PTR_W-1:0]      hz_rd_data;

   logic                  lst_wr_en;
   logic [LST_AW-1:0]     lst_wr_addr;
   logic [LST_W-1:0]      lst_wr_data;
   logic                  lst_rd_en;
   logic [LST_W-1:0]      lst_rd_data;

   logic                  req_accept;
   logic                  out_free;
   logic                  csr_write;
   logic [ACT_W-1:0]      threads;
   logic [SLOT_CNT_W-1:0] num_slots;
   logic                  slot_match;
   logic                  set_in_range;
   logic                  last_entry;
   logic                  last_slot;

   hpr_ram #(
      .WIDTH (PTR_W),
      .DEPTH (HAZARD_SLOTS)
   ) u_hazard_ram (
      .clock   (clock),
      .wr_en   (hz_wr_en),
      .wr_addr (hz_wr_addr),
      .wr_data (req_pointer),
      .rd_en   (hz_rd_en),
      .rd_addr (hz_rd_addr),
      .rd_data (hz_rd_data)
   );

   hpr_ram #(
      .WIDTH (LST_W),
      .DEPTH (RETIRE_DEPTH)
   ) u_retire_ram (
      .clock   (clock),
      .wr_en   (lst_wr_en),
      .wr_addr (lst_wr_addr),
      .wr_data (lst_wr_data),
      .rd_en   (lst_rd_en),
      .rd_addr (idx_ff),
      .rd_data (lst_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE) || (out_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !out_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_ACTIVE_THREADS);
   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_THREADS) ? CSR_DW'(active_ff) : '0;

   assign threads    = (32'(active_ff) > MAX_THREADS) ? ACT_W'(MAX_THREADS) : active_ff;
   assign num_slots  = SLOT_CNT_W'(32'(threads) * SLOTS_PER_THREAD);
   assign last_slot  = (SLOT_CNT_W'(slot_ff) == num_slots - SLOT_CNT_W'(1));
   assign last_entry = (idx_ff == LST_AW'(RETIRE_DEPTH - 1));
   assign slot_match = hv_ff && (hz_rd_data != '0) && (hz_rd_data == ent_ptr_ff);

   assign set_in_range = (32'(req_thread_id) < MAX_THREADS) &&
                         (32'(req_slot_index) < SLOTS_PER_THREAD);
   assign hz_wr_en   = req_accept && (req_cmd == CMD_SET) && set_in_range;
   assign hz_wr_addr = HAZ_AW'(32'(req_thread_id) * SLOTS_PER_THREAD + 32'(req_slot_index));
   assign hz_rd_en   = (state_ff == S_LOAD) || (state_ff == S_CMP);
   assign hz_rd_addr = (state_ff == S_LOAD) ? '0 : slot_ff + HAZ_AW'(1);

   assign lst_rd_en  = (state_ff == S_READ);

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      hz_valid_in   = hz_valid_ff;
      hv_in         = hv_ff;
      ent_ptr_in    = ent_ptr_ff;
      ent_tag_in    = ent_tag_ff;
      pend_valid_in = pend_valid_ff;
      pend_ptr_in   = pend_ptr_ff;
      pend_tag_in   = pend_tag_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_ptr_in    = out_ptr_ff;
      out_tag_in    = out_tag_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      lst_wr_en     = 1'b0;
      lst_wr_addr   = count_ff[LST_AW-1:0];
      lst_wr_data   = {req_pointer, req_callback_tag};

      if (csr_write) begin
         active_in = csr_pwdata[ACT_W-1:0];
      end

      if (hz_rd_en) begin
         hv_in = hz_valid_ff[hz_rd_addr];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_SET) begin
                  if (set_in_range) begin
                     hz_valid_in[hz_wr_addr] = 1'b1;
                  end
               end else if (count_ff == CNT_W'(RETIRE_DEPTH)) begin
                  out_valid_in  = 1'b1;
                  out_ptr_in    = req_pointer;
                  out_tag_in    = req_callback_tag;
                  out_status_in = STATUS_REJECTED;
                  out_last_in   = 1'b1;
               end else begin
                  lst_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  if (count_ff == CNT_W'(RETIRE_DEPTH - 1)) begin
                     idx_in        = '0;
                     kept_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            ent_ptr_in = lst_rd_data[LST_W-1:TAG_W];
            ent_tag_in = lst_rd_data[TAG_W-1:0];
            slot_in    = '0;
            hit_in     = 1'b0;
            state_in   = (num_slots == '0) ? S_DECIDE : S_CMP;
         end
         S_CMP: begin
            hit_in  = hit_ff || slot_match;
            slot_in = slot_ff + HAZ_AW'(1);
            if (last_slot) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (hit_ff || !pend_valid_ff || out_free) begin
               if (hit_ff) begin
                  lst_wr_en   = 1'b1;
                  lst_wr_addr = kept_ff[LST_AW-1:0];
                  lst_wr_data = {ent_ptr_ff, ent_tag_ff};
                  kept_in     = kept_ff + CNT_W'(1);
               end else begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_ptr_in    = pend_ptr_ff;
                     out_tag_in    = pend_tag_ff;
                     out_status_in = STATUS_FREED;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_ptr_in   = ent_ptr_ff;
                  pend_tag_in   = ent_tag_ff;
               end
               if (last_entry) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + LST_AW'(1);
                  state_in = S_READ;
               end
            end
         end
         S_FINISH: begin
            count_in = kept_ff;
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_ptr_in    = pend_ptr_ff;
               out_tag_in    = pend_tag_ff;
               out_status_in = STATUS_FREED;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= ACTIVE_THREADS_RESET;
         count_ff      <= '0;
         hz_valid_ff   <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         hz_valid_ff   <= hz_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kept_ff       <= kept_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      hv_ff         <= hv_in;
      ent_ptr_ff    <= ent_ptr_in;
      ent_tag_ff    <= ent_tag_in;
      pend_ptr_ff   <= pend_ptr_in;
      pend_tag_ff   <= pend_tag_in;
      out_ptr_ff    <= out_ptr_in;
      out_tag_ff    <= out_tag_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_freed_pointer = out_ptr_ff;
   assign rsp_freed_tag     = out_tag_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_last          = out_last_ff;

   // The retire list never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RETIRE_DEPTH))
      else $error("retire count exceeds list depth");

   // A rejected retire is always the only, and so the last, word of its command.
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REJECTED) |-> rsp_last)
      else $error("rejected word without last mark");

   // The retire that fills the list starts a scan on the next cycle.
   a_fill_scans: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_cmd == CMD_RETIRE) && (count_ff == CNT_W'(RETIRE_DEPTH - 1))
      |=> (state_ff == S_READ) && (idx_ff == '0))
      else $error("full list did not start a scan");

   // Compaction never writes ahead of the entry being scanned.
   a_kept_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> (kept_ff <= CNT_W'(idx_ff)))
      else $error("kept index passed scan index");

endmodule

// ----- rtl/core/hpr_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the hazard table and the retire list.
module hpr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/hazard_pointer_reclaimer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of hazard_pointer_reclaimer: hazard sets, retires, scans and
// rejections at a stuck list, under idling, stalls and several active thread counts.
// Depends on hpr_pkg and the RTL of the block only.
module hazard_pointer_reclaimer_tb;
   import hpr_pkg::*;

   localparam int SCAN_CYCLES     = RETIRE_DEPTH * (SLOTS_PER_THREAD * MAX_THREADS + 3) + 1;
   localparam int SETTLE_CYCLES   = SCAN_CYCLES + 64;
   localparam int PRESSURE_CYCLES = 3000;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_WORDS    = 32;
   localparam int POOL_SIZE       = 6;
   localparam logic [CSR_AW-1:0] ADDR_ACTIVE_THREADS = CSR_AW'(4 * REG_ACTIVE_THREADS);

   typedef struct packed {
      logic             cmd;
      logic [2:0]       thread_id;
      logic [1:0]       slot_index;
      logic [PTR_W-1:0] pointer;
      logic [TAG_W-1:0] callback_tag;
   } hp_word_type;

   typedef struct packed {
      logic [PTR_W-1:0] freed_pointer;
      logic [TAG_W-1:0] freed_tag;
      logic             status;
      logic             last;
   } free_word_type;

   typedef struct packed {
      hp_word_type   word;
      logic          typed;
      free_word_type outcome;
   } stim_row_type;

   localparam stim_row_type OPENING_ROWS [21] = '{
      '{'{CMD_SET,    3'd0, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00}, 1'b0, '0},
      '{'{CMD_SET,    3'd7, 2'd3, 64'h0000_0000_0000_0001, 8'h00}, 1'b0, '0},
      '{'{CMD_SET,    3'd3, 2'd2, 64'h5555_5555_5555_5555, 8'h00}, 1'b0, '0},
      '{'{CMD_SET,    3'd3, 2'd2, 64'h0000_0000_0000_0000, 8'h00}, 1'b0, '0},
      '{'{CMD_SET,    3'd4, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA, 8'hFF}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd7, 2'd3, 64'h0000_0000_0000_0001, 8'hFF}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd1, 2'd1, 64'h0000_0000_0000_0000, 8'h01}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd2, 2'd2, 64'h5555_5555_5555_5555, 8'h02}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd5, 2'd0, 64'hAAAA_AAAA_AAAA_AAAA, 8'h03}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd6, 2'd3, 64'hFFFF_FFFF_FFFF_FFFE, 8'h04}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h0000_0000_0000_0002, 8'h05}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h8000_0000_0000_0000, 8'h80}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF, 8'h7F}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h0000_0001_0000_0000, 8'h10}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h0000_0000_0000_0001, 8'h20}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h0123_4567_89AB_CDEF, 8'h5A}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'hFEDC_BA98_7654_3210, 8'hA5}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h0000_0000_FFFF_FFFF, 8'h11}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'hAAAA_AAAA_AAAA_AAAB, 8'h12}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h0000_0000_0000_0003, 8'hFE}, 1'b0, '0}
   };

   localparam stim_row_type STUCK_ROWS [6] = '{
      '{'{CMD_RETIRE, 3'd7, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF}, 1'b1,
        '{64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, STATUS_REJECTED, 1'b1}},
      '{'{CMD_RETIRE, 3'd0, 2'd0, 64'h0000_0000_0000_0000, 8'h00}, 1'b1,
        '{64'h0000_0000_0000_0000, 8'h00, STATUS_REJECTED, 1'b1}},
      '{'{CMD_SET,    3'd5, 2'd1, 64'h0000_0000_0000_0000, 8'h00}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd2, 2'd1, 64'h0123_4567_89AB_CDEF, 8'h5A}, 1'b1,
        '{64'h0123_4567_89AB_CDEF, 8'h5A, STATUS_REJECTED, 1'b1}},
      '{'{CMD_SET,    3'd0, 2'd0, 64'h0000_0000_0000_0001, 8'h00}, 1'b0, '0},
      '{'{CMD_RETIRE, 3'd5, 2'd2, 64'h8000_0000_0000_0000, 8'h80}, 1'b1,
        '{64'h8000_0000_0000_0000, 8'h80, STATUS_REJECTED, 1'b1}}
   };

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic              req_cmd          = CMD_SET;
   logic [2:0]        req_thread_id    = '0;
   logic [1:0]        req_slot_index   = '0;
   logic [PTR_W-1:0]  req_pointer      = '0;
   logic [TAG_W-1:0]  req_callback_tag = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [PTR_W-1:0]  rsp_freed_pointer;
   logic [TAG_W-1:0]  rsp_freed_tag;
   logic              rsp_status;
   logic              rsp_last;
   logic              csr_psel         = 1'b0;
   logic              csr_penable      = 1'b0;
   logic              csr_pwrite       = 1'b0;
   logic [CSR_AW-1:0] csr_paddr        = '0;
   logic [CSR_DW-1:0] csr_pwdata       = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   logic [PTR_W-1:0] hazard_copy [HAZARD_SLOTS];
   logic [PTR_W-1:0] retire_addr_copy [RETIRE_DEPTH];
   logic [TAG_W-1:0] retire_tag_copy [RETIRE_DEPTH];
   int unsigned      retire_fill;
   logic [ACT_W-1:0] thread_limit;
   logic [PTR_W-1:0] pointer_pool [POOL_SIZE];
   free_word_type    scan_out [$];
   free_word_type    frees_due [$];
   free_word_type    front_due;

   int          idle_pct       = 0;
   int          stall_pct      = 0;
   bit          pressure_on    = 1'b0;
   int          pressure_count = 0;
   bit          failed         = 1'b0;
   int unsigned cycle_count    = 0;

   hazard_pointer_reclaimer dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL hazard_pointer_reclaimer");
         $finish;
      end
   end

   // The long hold-off lets the block fill up and stall its input.
   always @(negedge clock) begin
      if (pressure_on && pressure_count < PRESSURE_CYCLES) begin
         rsp_stall <= 1'b1;
         pressure_count <= pressure_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic bit guarded(input logic [PTR_W-1:0] addr);
      int unsigned threads;
      int t;
      int s;
      threads = (thread_limit > MAX_THREADS) ? MAX_THREADS : thread_limit;
      for (t = 0; t < threads; t++) begin
         for (s = 0; s < SLOTS_PER_THREAD; s++) begin
            if (hazard_copy[t * SLOTS_PER_THREAD + s] != '0 &&
                hazard_copy[t * SLOTS_PER_THREAD + s] == addr)
               return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void reclaim_predict(input hp_word_type w);
      int unsigned kept;
      int i;
      scan_out.delete();
      if (w.cmd == CMD_SET) begin
         if (w.thread_id < MAX_THREADS && w.slot_index < SLOTS_PER_THREAD)
            hazard_copy[w.thread_id * SLOTS_PER_THREAD + w.slot_index] = w.pointer;
         return;
      end
      if (retire_fill >= RETIRE_DEPTH) begin
         scan_out.push_back(free_word_type'{w.pointer, w.callback_tag, STATUS_REJECTED, 1'b1});
         return;
      end
      retire_addr_copy[retire_fill] = w.pointer;
      retire_tag_copy[retire_fill] = w.callback_tag;
      retire_fill++;
      if (retire_fill == RETIRE_DEPTH) begin
         kept = 0;
         for (i = 0; i < RETIRE_DEPTH; i++) begin
            if (guarded(retire_addr_copy[i])) begin
               retire_addr_copy[kept] = retire_addr_copy[i];
               retire_tag_copy[kept] = retire_tag_copy[i];
               kept++;
            end else begin
               scan_out.push_back(free_word_type'{retire_addr_copy[i], retire_tag_copy[i],
                                                  STATUS_FREED, 1'b0});
            end
         end
         retire_fill = kept;
         if (scan_out.size() > 0)
            scan_out[scan_out.size() - 1].last = 1'b1;
      end
   endfunction

   // A retire that would leave all sixteen entries held can never be scanned again.
   function automatic bit would_stick(input logic [PTR_W-1:0] ptr);
      int i;
      if (retire_fill != RETIRE_DEPTH - 1 || !guarded(ptr))
         return 1'b0;
      for (i = 0; i < RETIRE_DEPTH - 1; i++) begin
         if (!guarded(retire_addr_copy[i]))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] pick_pointer(input logic cmd);
      int unsigned roll;
      roll = $urandom_range(99);
      if (cmd == CMD_SET && roll < 15)
         return '0;
      if (roll < 75)
         return pointer_pool[$urandom_range(POOL_SIZE - 1)];
      return {$urandom(), $urandom()};
   endfunction

   function automatic void check_field(input string name, input logic [PTR_W-1:0] want,
                                       input logic [PTR_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frees_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h %h %b %b", $time,
                     rsp_freed_pointer, rsp_freed_tag, rsp_status, rsp_last);
            failed = 1'b1;
         end else begin
            front_due = frees_due.pop_front();
            check_field("freed_pointer", front_due.freed_pointer, rsp_freed_pointer);
            check_field("freed_tag", PTR_W'(front_due.freed_tag), PTR_W'(rsp_freed_tag));
            check_field("status", PTR_W'(front_due.status), PTR_W'(rsp_status));
            check_field("last", PTR_W'(front_due.last), PTR_W'(rsp_last));
         end
      end
   end

   task automatic issue(input hp_word_type w, input logic typed,
                        input free_word_type outcome);
      int k;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= w.cmd;
      req_thread_id <= w.thread_id;
      req_slot_index <= w.slot_index;
      req_pointer <= w.pointer;
      req_callback_tag <= w.callback_tag;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      reclaim_predict(w);
      if (typed) begin
         frees_due.push_back(outcome);
      end else begin
         for (k = 0; k < scan_out.size(); k++)
            frees_due.push_back(scan_out[k]);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frees_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threads(input logic [ACT_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_ACTIVE_THREADS;
      csr_pwdata <= {(CSR_DW - ACT_W)'($urandom()), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      thread_limit = value;
   endtask

   task automatic random_phase(input int words);
      hp_word_type w;
      int n;
      for (n = 0; n < words; n++) begin
         w.cmd = ($urandom_range(99) < 60) ? CMD_RETIRE : CMD_SET;
         w.thread_id = 3'($urandom_range(7));
         w.slot_index = 2'($urandom_range(3));
         w.callback_tag = TAG_W'($urandom_range(255));
         w.pointer = pick_pointer(w.cmd);
         if (w.cmd == CMD_RETIRE) begin
            while (would_stick(w.pointer))
               w.pointer = {$urandom(), $urandom()};
         end
         issue(w, 1'b0, '0);
      end
   endtask

   initial begin
      hp_word_type w;
      int i;
      for (i = 0; i < HAZARD_SLOTS; i++)
         hazard_copy[i] = '0;
      retire_fill = 0;
      thread_limit = ACTIVE_THREADS_RESET;
      pointer_pool[0] = '1;
      pointer_pool[1] = PTR_W'(1);
      for (i = 2; i < POOL_SIZE; i++)
         pointer_pool[i] = {$urandom(), $urandom()};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(OPENING_ROWS); i++)
         issue(OPENING_ROWS[i].word, OPENING_ROWS[i].typed, OPENING_ROWS[i].outcome);

      settle();
      write_threads(ACT_W'(MAX_THREADS));
      random_phase(RANDOM_WORDS);

      settle();
      idle_pct = 51;
      write_threads(ACT_W'(1));
      random_phase(RANDOM_WORDS);

      settle();
      idle_pct = 0;
      stall_pct = 51;
      write_threads(ACT_W'(0));
      random_phase(RANDOM_WORDS);

      settle();
      idle_pct = 10;
      stall_pct = 10;
      write_threads(ACT_W'(15));
      pressure_on = 1'b1;
      random_phase(RANDOM_WORDS);

      settle();
      idle_pct = 0;
      stall_pct = 0;
      write_threads(ACT_W'($urandom_range(1, MAX_THREADS)));
      random_phase(RANDOM_WORDS);

      // Fill the list with a held node until a scan keeps every entry, then retire into it.
      settle();
      stall_pct = 51;
      write_threads(ACT_W'(MAX_THREADS));
      w = '{CMD_SET, 3'd5, 2'd1, pointer_pool[2], 8'h00};
      issue(w, 1'b0, '0);
      while (retire_fill != RETIRE_DEPTH) begin
         w = '{CMD_RETIRE, 3'($urandom_range(7)), 2'($urandom_range(3)), pointer_pool[2],
               TAG_W'($urandom_range(255))};
         issue(w, 1'b0, '0);
      end
      for (i = 0; i < $size(STUCK_ROWS); i++)
         issue(STUCK_ROWS[i].word, STUCK_ROWS[i].typed, STUCK_ROWS[i].outcome);

      settle();
      if (!failed && frees_due.size() == 0)
         $display("PASS hazard_pointer_reclaimer");
      else
         $display("FAIL hazard_pointer_reclaimer");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/hpr_pkg.sv
rtl/core/hpr_ram.sv
rtl/core/hazard_pointer_reclaimer.sv
tb/sv/hazard_pointer_reclaimer_tb.sv
